// ===== sv/wheel_torque_command_limiter_defines.svh =====
// ----------------------------------------------------------------------------
// wheel torque command limiter assertion macros
// shared property forms for the limiter modules
// ----------------------------------------------------------------------------
`ifndef WHEEL_TORQUE_COMMAND_LIMITER_DEFINES_SVH
`define WHEEL_TORQUE_COMMAND_LIMITER_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define WTCL_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define WTCL_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/wtcl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtcl_pkg
// shared widths, defaults and types of the wheel torque command limiter
// ----------------------------------------------------------------------------
package wtcl_pkg;

    // default parameter values
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH_DEF = 4;

    // fixed register widths
    localparam int LIMIT_W = 31;
    localparam int POWER_W = 48;

    // limit settings as seen by the datapath
    typedef struct packed {
        logic [LIMIT_W-1:0] torque_limit;
        logic [LIMIT_W-1:0] torque_deadband;
        logic [POWER_W-1:0] power_limit;
        logic [LIMIT_W-1:0] speed_limit;
    } wtcl_cfg_t;

    // classification of one transaction by the front end
    typedef struct packed {
        logic t_neg;
        logic clamped;
        logic dead;
        logic pwr_en;
        logic spd_cond;
    } wtcl_flags_t;

    // flags reported with a result
    typedef struct packed {
        logic torque_clamped;
        logic deadband_zeroed;
        logic power_limited;
        logic speed_blocked;
    } wtcl_res_flags_t;

endpackage

// ===== sv/wtcl_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtcl_front
// splits command and speed into sign and magnitude, applies the torque clamp
// and deadband, and classifies the power and speed conditions
// ----------------------------------------------------------------------------
module wtcl_front
    import wtcl_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wtcl_cfg_t                      cfg,
    input  logic signed [VALUE_WIDTH-1:0]  torque_command,
    input  logic signed [VALUE_WIDTH-1:0]  wheel_speed,
    output wtcl_flags_t                    flags,
    output logic        [VALUE_WIDTH-1:0]  t_mag,
    output logic        [VALUE_WIDTH-1:0]  s_mag
);

    localparam int MW = (VALUE_WIDTH > LIMIT_W) ? VALUE_WIDTH : LIMIT_W;
    localparam logic [VALUE_WIDTH-1:0] VAL_ONE = VALUE_WIDTH'(1);

    logic                   t_neg;
    logic                   s_neg;
    logic [VALUE_WIDTH-1:0] t_raw;
    logic [VALUE_WIDTH-1:0] s_raw;
    logic [VALUE_WIDTH-1:0] t_abs;
    logic [VALUE_WIDTH-1:0] s_abs;
    logic [VALUE_WIDTH-1:0] t_clamp;
    logic                   clamped;
    logic                   dead;

    // sign and magnitude
    always_comb begin
        t_raw = torque_command;
        s_raw = wheel_speed;
        t_neg = t_raw[VALUE_WIDTH-1];
        s_neg = s_raw[VALUE_WIDTH-1];
        t_abs = t_neg ? (~t_raw + VAL_ONE) : t_raw;
        s_abs = s_neg ? (~s_raw + VAL_ONE) : s_raw;
    end

    // torque clamp
    always_comb begin
        t_clamp = t_abs;
        clamped = 1'b0;
        if ((cfg.torque_limit != '0) && (MW'(t_abs) > MW'(cfg.torque_limit))) begin
            t_clamp = VALUE_WIDTH'(cfg.torque_limit);
            clamped = 1'b1;
        end
    end

    // deadband
    always_comb begin
        t_mag = t_clamp;
        dead  = 1'b0;
        if ((t_clamp != '0) && (MW'(t_clamp) < MW'(cfg.torque_deadband))) begin
            t_mag = '0;
            dead  = 1'b1;
        end
    end

    // classification for the back end
    always_comb begin
        s_mag          = s_abs;
        flags.t_neg    = t_neg;
        flags.clamped  = clamped;
        flags.dead     = dead;
        flags.pwr_en   = (cfg.power_limit != '0) && (s_abs != '0);
        flags.spd_cond = (cfg.speed_limit != '0)
                      && (MW'(s_abs) >= MW'(cfg.speed_limit))
                      && ((s_abs == '0) || (t_neg == s_neg));
    end

endmodule

// ===== sv/wtcl_queue.sv =====
`timescale 1ns / 1ps
`include "wheel_torque_command_limiter_defines.svh"
// ----------------------------------------------------------------------------
// wtcl_queue
// short first-in first-out queue between the front and back ends
// ----------------------------------------------------------------------------
module wtcl_queue
    import wtcl_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // status and head of the queue
    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign pop_data = data_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : (wr_ptr_reg + PTR_ONE);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : (rd_ptr_reg + PTR_ONE);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_ONE;
        end else if (pop && !push) begin
            count_next = count_reg - CNT_ONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

    // checks
    `WTCL_ASSERT_SAME(a_no_underflow, aclk, aresetn, pop, !empty, "pop from empty queue")
    `WTCL_ASSERT_NEXT(a_count_up, aclk, aresetn, push && !pop, count_reg == CNT_W'($past(count_reg) + CNT_ONE), "fill count missed a push")

endmodule

// ===== sv/wtcl_back.sv =====
`timescale 1ns / 1ps
`include "wheel_torque_command_limiter_defines.svh"
// ----------------------------------------------------------------------------
// wtcl_back
// pipelined restoring divider for the power limit, then the power and speed
// limits and the result register
// ----------------------------------------------------------------------------
module wtcl_back
    import wtcl_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [POWER_W-1:0]             power_limit,
    input  logic                           head_valid,
    output logic                           pop,
    input  wtcl_flags_t                    in_flags,
    input  logic        [VALUE_WIDTH-1:0]  in_t_mag,
    input  logic        [VALUE_WIDTH-1:0]  in_s_mag,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [VALUE_WIDTH-1:0]  m_applied_torque,
    output wtcl_res_flags_t                m_flags
);

    localparam int QW = POWER_W;
    localparam int VW = VALUE_WIDTH;

    typedef struct packed {
        wtcl_flags_t     flags;
        logic [VW-1:0]   t_mag;
        logic [VW-1:0]   s_mag;
        logic [VW-1:0]   rem;
        logic [QW-1:0]   quot;
    } stage_t;

    logic            advance;
    logic            stg_valid_reg [QW];
    stage_t          stg_reg       [QW];
    stage_t          stg_next      [QW];

    stage_t          last;
    logic            pwr_hit;
    logic [VW-1:0]   t_pwr;
    logic            sblk;
    logic [VW-1:0]   t_fin;

    logic                   m_valid_reg;
    logic [VW-1:0]          m_torque_reg;
    wtcl_res_flags_t        m_flags_reg;
    logic [VW-1:0]          m_torque_next;
    wtcl_res_flags_t        m_flags_next;

    // the whole pipeline moves when the result register can take a value
    assign advance = !m_valid_reg || m_ready;
    assign pop     = advance && head_valid;

    // one quotient bit per stage, most significant first
    for (genvar k = 0; k < QW; k++) begin : g_stage
        stage_t        src;
        logic          src_valid;
        logic [VW:0]   trial;
        logic [VW:0]   diff;

        if (k == 0) begin : g_first
            always_comb begin
                src_valid   = head_valid;
                src.flags   = in_flags;
                src.t_mag   = in_t_mag;
                src.s_mag   = in_s_mag;
                src.rem     = '0;
                src.quot    = '0;
            end
        end else begin : g_rest
            always_comb begin
                src_valid = stg_valid_reg[k-1];
                src       = stg_reg[k-1];
            end
        end

        // trial subtract of the divisor
        always_comb begin
            trial       = {src.rem, power_limit[QW-1-k]};
            diff        = trial - {1'b0, src.s_mag};
            stg_next[k] = src;
            stg_next[k].rem  = diff[VW] ? trial[VW-1:0] : diff[VW-1:0];
            stg_next[k].quot = {src.quot[QW-2:0], ~diff[VW]};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                stg_valid_reg[k] <= 1'b0;
            end else if (advance) begin
                stg_valid_reg[k] <= src_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (advance) begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

    // power and speed limits on the finished quotient
    always_comb begin
        last    = stg_reg[QW-1];
        pwr_hit = last.flags.pwr_en
               && ((QW'(last.t_mag) > last.quot)
                   || ((QW'(last.t_mag) == last.quot) && (last.rem == '0)));
        t_pwr   = pwr_hit ? VW'(last.quot) : last.t_mag;
        sblk    = last.flags.spd_cond && (t_pwr != '0);
        t_fin   = sblk ? '0 : t_pwr;

        m_torque_next = last.flags.t_neg ? (~t_fin + VW'(1)) : t_fin;
        m_flags_next.torque_clamped  = last.flags.clamped;
        m_flags_next.deadband_zeroed = last.flags.dead;
        m_flags_next.power_limited   = pwr_hit;
        m_flags_next.speed_blocked   = sblk;
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= stg_valid_reg[QW-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_torque_reg <= m_torque_next;
            m_flags_reg  <= m_flags_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_applied_torque = m_torque_reg;
    assign m_flags          = m_flags_reg;

    // checks
    `WTCL_ASSERT_SAME(a_dead_alone, aclk, aresetn, m_valid_reg && m_flags_reg.deadband_zeroed, !m_flags_reg.power_limited && !m_flags_reg.speed_blocked && (m_torque_reg == '0), "deadband result not alone or not zero")
    `WTCL_ASSERT_SAME(a_block_zero, aclk, aresetn, m_valid_reg && m_flags_reg.speed_blocked, m_torque_reg == '0, "speed block left a nonzero torque")
    `WTCL_ASSERT_NEXT(a_drain, aclk, aresetn, stg_valid_reg[QW-1] && advance, m_valid_reg, "last divider stage lost a transaction")

endmodule

// ===== sv/wheel_torque_command_limiter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wheel_torque_command_limiter
// reaction wheel torque command limiter: clamp, deadband, power and speed
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one torque command and wheel speed per transaction, taken
//   when s_valid and s_ready are high. m_ channel: the applied torque and
//   four flags telling which limits acted, one result per transaction.
//   limits are set through the APB port (64-bit data, registers 8 bytes
//   apart); the user must change them only while no transaction is in flight, as the block does not enforce it.
// latency and throughput
//   one transaction per cycle while no stall holds the pipeline. a
//   result passes through the queue, runs down the 48-stage divider
//   pipeline and is then loaded into the result register. the divider
//   pipeline sets the latency.
// reset
//   synchronous, active low: all limits read 0, queue and pipeline empty.
// stall
//   while m_ready is low and a result waits, the divider pipeline holds;
//   the front queue keeps taking transactions until its four entries fill.
// ----------------------------------------------------------------------------
module wheel_torque_command_limiter
    import wtcl_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // command channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [VALUE_WIDTH-1:0]  s_torque_command,
    input  logic signed [VALUE_WIDTH-1:0]  s_wheel_speed,
    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [VALUE_WIDTH-1:0]  m_applied_torque,
    output logic                           m_torque_clamped,
    output logic                           m_deadband_zeroed,
    output logic                           m_power_limited,
    output logic                           m_speed_blocked,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [4:0]                     paddr,
    input  logic [63:0]                    pwdata,
    output logic [63:0]                    prdata,
    output logic                           pready
);

    localparam int DATA_W = 64;
    localparam int QD_W   = $bits(wtcl_flags_t) + 2 * VALUE_WIDTH;

    localparam logic [1:0] REG_TORQUE_LIMIT = 2'd0;
    localparam logic [1:0] REG_DEADBAND     = 2'd1;
    localparam logic [1:0] REG_POWER_LIMIT  = 2'd2;
    localparam logic [1:0] REG_SPEED_LIMIT  = 2'd3;

    logic [LIMIT_W-1:0]     torque_limit_reg;
    logic [LIMIT_W-1:0]     deadband_reg;
    logic [POWER_W-1:0]     power_limit_reg;
    logic [LIMIT_W-1:0]     speed_limit_reg;
    logic [1:0]             reg_idx;
    logic                   cfg_wr;
    wtcl_cfg_t              cfg;

    wtcl_flags_t            f_flags;
    logic [VALUE_WIDTH-1:0] f_t_mag;
    logic [VALUE_WIDTH-1:0] f_s_mag;
    logic                   q_full;
    logic                   q_empty;
    logic                   q_push;
    logic                   q_pop;
    logic [QD_W-1:0]        q_push_data;
    logic [QD_W-1:0]        q_pop_data;
    wtcl_flags_t            b_flags;
    logic [VALUE_WIDTH-1:0] b_t_mag;
    logic [VALUE_WIDTH-1:0] b_s_mag;
    wtcl_res_flags_t        res_flags;

    // register file
    assign reg_idx = paddr[4:3];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            torque_limit_reg <= '0;
            deadband_reg     <= '0;
            power_limit_reg  <= '0;
            speed_limit_reg  <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_TORQUE_LIMIT: torque_limit_reg <= pwdata[LIMIT_W-1:0];
                REG_DEADBAND:     deadband_reg     <= pwdata[LIMIT_W-1:0];
                REG_POWER_LIMIT:  power_limit_reg  <= pwdata[POWER_W-1:0];
                REG_SPEED_LIMIT:  speed_limit_reg  <= pwdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        case (reg_idx)
            REG_TORQUE_LIMIT: prdata = DATA_W'(torque_limit_reg);
            REG_DEADBAND:     prdata = DATA_W'(deadband_reg);
            REG_POWER_LIMIT:  prdata = DATA_W'(power_limit_reg);
            REG_SPEED_LIMIT:  prdata = DATA_W'(speed_limit_reg);
            default:          prdata = '0;
        endcase
    end

    always_comb begin
        cfg.torque_limit    = torque_limit_reg;
        cfg.torque_deadband = deadband_reg;
        cfg.power_limit     = power_limit_reg;
        cfg.speed_limit     = speed_limit_reg;
    end

    // front end: clamp, deadband and classification
    wtcl_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .cfg            (cfg),
        .torque_command (s_torque_command),
        .wheel_speed    (s_wheel_speed),
        .flags          (f_flags),
        .t_mag          (f_t_mag),
        .s_mag          (f_s_mag)
    );

    // queue between front and back
    assign s_ready     = !q_full;
    assign q_push      = s_valid && !q_full;
    assign q_push_data = {f_flags, f_t_mag, f_s_mag};

    wtcl_queue #(
        .WIDTH (QD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    assign {b_flags, b_t_mag, b_s_mag} = q_pop_data;

    // back end: divider pipeline, power and speed limits
    wtcl_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .power_limit      (power_limit_reg),
        .head_valid       (!q_empty),
        .pop              (q_pop),
        .in_flags         (b_flags),
        .in_t_mag         (b_t_mag),
        .in_s_mag         (b_s_mag),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_applied_torque (m_applied_torque),
        .m_flags          (res_flags)
    );

    assign m_torque_clamped  = res_flags.torque_clamped;
    assign m_deadband_zeroed = res_flags.deadband_zeroed;
    assign m_power_limited   = res_flags.power_limited;
    assign m_speed_blocked   = res_flags.speed_blocked;

endmodule

// ===== tb/wheel_torque_command_limiter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wheel_torque_command_limiter_tb
// self-checking bench for the reaction wheel torque command limiter: a
// queue-fed driver offers commands, a predictor works out the applied torque
// and limit flags for each accepted transaction, and a monitor compares every
// result with the oldest prediction. limits change over the APB port between
// phases, once the block has drained.
// ----------------------------------------------------------------------------
module wheel_torque_command_limiter_tb;
    import wtcl_pkg::*;

    localparam int VW = VALUE_WIDTH_DEF;

    // register indexes and byte spacing on the APB port
    localparam int REG_TORQUE_LIMIT = 0;
    localparam int REG_DEADBAND     = 1;
    localparam int REG_POWER_LIMIT  = 2;
    localparam int REG_SPEED_LIMIT  = 3;
    localparam int REG_STRIDE       = 8;

    localparam logic [63:0]   LIMIT_MAX = (64'd1 << LIMIT_W) - 64'd1;
    localparam logic [63:0]   POWER_MAX = (64'd1 << POWER_W) - 64'd1;
    localparam logic [VW-1:0] MOST_NEG  = {1'b1, {(VW-1){1'b0}}};
    localparam logic [VW-1:0] MOST_POS  = {1'b0, {(VW-1){1'b1}}};

    localparam int CYCLE_LIMIT      = 400000;
    localparam int DRAIN_CYCLES     = POWER_W + 16;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int LONG_HOLD_AFTER  = 500;
    localparam int RANDOM_PHASES    = 6;
    localparam int CMDS_PER_PHASE   = 170;

    typedef struct packed {
        logic [VW-1:0] torque;
        logic [VW-1:0] speed;
    } wheel_cmd_t;

    typedef struct packed {
        logic [VW-1:0]   torque;
        wtcl_res_flags_t flags;
    } torque_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic signed [VW-1:0] s_torque_command = '0;
    logic signed [VW-1:0] s_wheel_speed = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic signed [VW-1:0] m_applied_torque;
    logic                 m_torque_clamped;
    logic                 m_deadband_zeroed;
    logic                 m_power_limited;
    logic                 m_speed_blocked;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [4:0]           paddr = '0;
    logic [63:0]          pwdata = '0;
    logic [63:0]          prdata;
    logic                 pready;

    // limits as the block should hold them
    logic [LIMIT_W-1:0] lim_torque = '0;
    logic [LIMIT_W-1:0] lim_deadband = '0;
    logic [POWER_W-1:0] lim_power = '0;
    logic [LIMIT_W-1:0] lim_speed = '0;

    wheel_cmd_t     command_q[$];
    torque_result_t applied_expect_q[$];

    int n_sent = 0;
    int n_accepted = 0;
    int n_results = 0;
    int n_errors = 0;
    int n_settings = 0;
    int cycles = 0;
    int n_clamped = 0;
    int n_deadband = 0;
    int n_power = 0;
    int n_blocked = 0;
    int tx_gap = 0;
    int rx_gap = 0;
    int long_hold_left = 0;
    bit long_hold_done = 1'b0;
    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;

    wheel_torque_command_limiter dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_torque_command  (s_torque_command),
        .s_wheel_speed     (s_wheel_speed),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_applied_torque  (m_applied_torque),
        .m_torque_clamped  (m_torque_clamped),
        .m_deadband_zeroed (m_deadband_zeroed),
        .m_power_limited   (m_power_limited),
        .m_speed_blocked   (m_speed_blocked),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    // clock
    always #10 aclk = ~aclk;

    // magnitude of a two's complement value, exact for the most negative one
    function automatic logic [63:0] magnitude(input logic [VW-1:0] v);
        if (v[VW-1]) begin
            return (64'd1 << VW) - 64'(v);
        end
        return 64'(v);
    endfunction

    // applied torque and limit flags for one command under the present limits
    function automatic torque_result_t limit_torque_command(input wheel_cmd_t cmd);
        torque_result_t res;
        logic           t_neg;
        logic           s_neg;
        logic [63:0]    t_mag;
        logic [63:0]    s_mag;
        logic [63:0]    quo;
        logic [63:0]    rem;
        res   = '0;
        t_neg = cmd.torque[VW-1];
        s_neg = cmd.speed[VW-1];
        t_mag = magnitude(cmd.torque);
        s_mag = magnitude(cmd.speed);
        // torque clamp
        if (lim_torque != 0 && t_mag > 64'(lim_torque)) begin
            t_mag = 64'(lim_torque);
            res.flags.torque_clamped = 1'b1;
        end
        // deadband, a zero command stays quiet
        if (t_mag != 0 && t_mag < 64'(lim_deadband)) begin
            t_mag = 0;
            res.flags.deadband_zeroed = 1'b1;
        end
        // |t|*|s| >= P exactly when |t| > P/|s|, or equal with nothing left over
        if (lim_power != 0 && s_mag != 0) begin
            quo = 64'(lim_power) / s_mag;
            rem = 64'(lim_power) % s_mag;
            if (t_mag > quo || (t_mag == quo && rem == 0)) begin
                t_mag = quo;
                res.flags.power_limited = 1'b1;
            end
        end
        // speed block when the torque would spin the wheel up further
        if (lim_speed != 0 && s_mag >= 64'(lim_speed) && t_mag != 0 && t_neg == s_neg) begin
            t_mag = 0;
            res.flags.speed_blocked = 1'b1;
        end
        res.torque = t_neg ? -t_mag[VW-1:0] : t_mag[VW-1:0];
        return res;
    endfunction

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap(input bit en);
        int unsigned pick;
        if (!en) begin
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            return 0;
        end else if (pick < 90) begin
            return int'($urandom_range(1, 3));
        end
        return int'($urandom_range(4, 30));
    endfunction

    function automatic logic [63:0] near_value(input logic [63:0] x);
        logic [63:0] v;
        v = x + 64'($urandom_range(0, 2));
        return (v == 0) ? 64'd0 : v - 64'd1;
    endfunction

    // clip a magnitude to the positive range and give it a random sign
    function automatic logic [VW-1:0] signed_value(input logic [63:0] mag);
        logic [63:0] m;
        m = (mag > 64'(MOST_POS)) ? 64'(MOST_POS) : mag;
        return $urandom_range(0, 1) ? -m[VW-1:0] : m[VW-1:0];
    endfunction

    function automatic logic [VW-1:0] extreme_value();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return VW'(1);
            2:       return '1;
            3:       return MOST_POS;
            default: return MOST_NEG;
        endcase
    endfunction

    function automatic logic [63:0] rand_limit(input int unsigned typical_max);
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
            return 64'd0;
        end else if (pick == 2) begin
            return LIMIT_MAX;
        end else if (pick == 3) begin
            return 64'($urandom_range(1, 16));
        end
        return 64'($urandom_range(1, typical_max));
    endfunction

    function automatic logic [63:0] rand_power();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
            return 64'd0;
        end else if (pick == 2) begin
            return POWER_MAX;
        end else if (pick == 3) begin
            return 64'($urandom_range(1, 16));
        end else if (pick == 4) begin
            return {$urandom, $urandom} & POWER_MAX;
        end
        return 64'($urandom_range(1, 1000000)) * 64'($urandom_range(1, 100000));
    endfunction

    // random command aimed at the limit boundaries of the present setting
    function automatic wheel_cmd_t random_cmd();
        wheel_cmd_t  cmd;
        logic [63:0] quo;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            cmd.speed = VW'($urandom);
        end else if (pick < 6) begin
            cmd.speed = signed_value(near_value(64'(lim_speed)));
        end else if (pick == 6) begin
            cmd.speed = '0;
        end else if (pick == 7) begin
            cmd.speed = extreme_value();
        end else begin
            cmd.speed = signed_value(64'($urandom_range(0, 500000)));
        end
        pick = $urandom_range(0, 9);
        if (pick < 3) begin
            cmd.torque = VW'($urandom);
        end else if (pick == 3) begin
            cmd.torque = signed_value(near_value(64'(lim_torque)));
        end else if (pick == 4) begin
            cmd.torque = signed_value(near_value(64'(lim_deadband)));
        end else if (pick < 7 && lim_power != 0) begin
            // just around the power boundary for this speed
            if (cmd.speed == 0) begin
                cmd.speed = signed_value(64'($urandom_range(1, 65536)));
            end
            quo = 64'(lim_power) / magnitude(cmd.speed);
            cmd.torque = signed_value(near_value(quo));
        end else if (pick == 7) begin
            cmd.torque = extreme_value();
        end else begin
            cmd.torque = signed_value(64'($urandom_range(0, 3000000)));
        end
        return cmd;
    endfunction

    function automatic void push_cmd(input logic [VW-1:0] torque, input logic [VW-1:0] speed);
        command_q.insert(command_q.size(), {torque, speed});
    endfunction

    task automatic check_field(input string field, input logic [VW-1:0] want,
                               input logic [VW-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, $signed(want), $signed(got));
            n_errors++;
        end
    endtask

    // one APB transfer: setup cycle, then access until pready
    task automatic apb_access(input int idx, input bit wr, input logic [63:0] wdata,
                              output logic [63:0] rdata);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= 5'(idx * REG_STRIDE);
        pwdata  <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // write all four limits, then read each one back
    task automatic set_limits(input logic [63:0] tl, input logic [63:0] db,
                              input logic [63:0] pl, input logic [63:0] sl);
        logic [63:0] rd;
        logic [63:0] want;
        string       name;
        apb_access(REG_TORQUE_LIMIT, 1'b1, tl, rd);
        lim_torque = tl[LIMIT_W-1:0];
        apb_access(REG_DEADBAND, 1'b1, db, rd);
        lim_deadband = db[LIMIT_W-1:0];
        apb_access(REG_POWER_LIMIT, 1'b1, pl, rd);
        lim_power = pl[POWER_W-1:0];
        apb_access(REG_SPEED_LIMIT, 1'b1, sl, rd);
        lim_speed = sl[LIMIT_W-1:0];
        n_settings++;
        for (int i = REG_TORQUE_LIMIT; i <= REG_SPEED_LIMIT; i++) begin
            apb_access(i, 1'b0, '0, rd);
            case (i)
                REG_TORQUE_LIMIT: begin
                    want = 64'(lim_torque);
                    name = "torque_limit";
                end
                REG_DEADBAND: begin
                    want = 64'(lim_deadband);
                    name = "torque_deadband";
                end
                REG_POWER_LIMIT: begin
                    want = 64'(lim_power);
                    name = "power_limit";
                end
                default: begin
                    want = 64'(lim_speed);
                    name = "speed_limit";
                end
            endcase
            if (rd !== want) begin
                $error("%s: expected %0h, got %0h", name, want, rd);
                n_errors++;
            end
        end
    endtask

    // sender pause: nothing pending, nothing offered, every result back
    task automatic wait_idle();
        while (command_q.size() != 0 || s_valid || applied_expect_q.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // command driver, fed from the pending queue
    always @(negedge aclk) begin : cmd_driver
        wheel_cmd_t next_cmd;
        if (!s_valid || n_accepted == n_sent) begin
            if (tx_gap > 0) begin
                s_valid <= 1'b0;
                tx_gap--;
            end else if (command_q.size() != 0) begin
                next_cmd = command_q.pop_front();
                s_valid          <= 1'b1;
                s_torque_command <= next_cmd.torque;
                s_wheel_speed    <= next_cmd.speed;
                n_sent++;
                tx_gap = pick_gap(tx_idle_en);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result ready: random stalls plus one long hold-off
    always @(negedge aclk) begin
        if (long_hold_left > 0) begin
            m_ready <= 1'b0;
            long_hold_left--;
        end else if (!long_hold_done && n_accepted >= LONG_HOLD_AFTER) begin
            long_hold_done = 1'b1;
            long_hold_left = LONG_HOLD_CYCLES - 1;
            m_ready <= 1'b0;
        end else if (rx_gap > 0) begin
            m_ready <= 1'b0;
            rx_gap--;
        end else begin
            m_ready <= 1'b1;
            if (rx_idle_en && $urandom_range(0, 3) == 0) begin
                rx_gap = pick_gap(1'b1);
            end
        end
    end

    // result check, then prediction for a newly accepted transaction
    always @(posedge aclk) begin : result_check
        torque_result_t want;
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (applied_expect_q.size() == 0) begin
                $error("unexpected result: applied_torque %0d", m_applied_torque);
                n_errors++;
            end else begin
                want = applied_expect_q.pop_front();
                check_field("applied_torque", want.torque, m_applied_torque);
                check_field("torque_clamped", VW'(want.flags.torque_clamped),
                            VW'(m_torque_clamped));
                check_field("deadband_zeroed", VW'(want.flags.deadband_zeroed),
                            VW'(m_deadband_zeroed));
                check_field("power_limited", VW'(want.flags.power_limited),
                            VW'(m_power_limited));
                check_field("speed_blocked", VW'(want.flags.speed_blocked),
                            VW'(m_speed_blocked));
            end
        end
        if (aresetn && s_valid && s_ready) begin
            want = limit_torque_command({s_torque_command, s_wheel_speed});
            applied_expect_q.insert(applied_expect_q.size(), want);
            n_accepted++;
            n_clamped  += int'(want.flags.torque_clamped);
            n_deadband += int'(want.flags.deadband_zeroed);
            n_power    += int'(want.flags.power_limited);
            n_blocked  += int'(want.flags.speed_blocked);
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     applied_expect_q.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // stimulus sequence
    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // all limits off: the command passes untouched
        set_limits(0, 0, 0, 0);
        push_cmd(MOST_NEG, 5);
        push_cmd(MOST_POS, '1);
        push_cmd(0, 0);
        push_cmd(12345, MOST_NEG);
        wait_idle();

        // moderate limits, one command per boundary
        set_limits(1000000, 1000, 50000000, 200000);
        push_cmd(0, 0);
        push_cmd(0, 300000);
        push_cmd(MOST_POS, 1);
        push_cmd(MOST_NEG, '1);
        push_cmd(500, 10);
        push_cmd(-999, 0);
        push_cmd(800000, 0);
        push_cmd(50000, 1000);
        push_cmd(-500000, 1000);
        push_cmd(16667, 3000);
        push_cmd(16666, -3000);
        push_cmd(2000, 200000);
        push_cmd(-2000, 200000);
        push_cmd(MOST_NEG, MOST_NEG);
        push_cmd(1, MOST_POS);
        push_cmd(-400000, -199999);
        wait_idle();

        // every limit at its top, bits above the register width dropped
        set_limits('1, LIMIT_MAX, POWER_MAX, LIMIT_MAX);
        push_cmd(MOST_NEG, MOST_NEG);
        push_cmd(5, 7);
        wait_idle();

        // every limit at one
        set_limits(1, 1, 1, 1);
        push_cmd(3, 1);
        push_cmd(-3, 1);
        push_cmd(0, '1);
        wait_idle();

        // random settings, each phase draining before the next
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            tx_idle_en = (p % 3 != 0);
            rx_idle_en = (p % 3 != 1);
            set_limits(rand_limit(3000000), rand_limit(20000), rand_power(),
                       rand_limit(600000));
            for (int k = 0; k < CMDS_PER_PHASE; k++) begin
                command_q.insert(command_q.size(), random_cmd());
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("%0d commands under %0d limit settings, %0d results compared",
                 n_accepted, n_settings, n_results);
        $display("limits acted: clamp %0d, deadband %0d, power %0d, speed block %0d",
                 n_clamped, n_deadband, n_power, n_blocked);
        if (n_errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/wtcl_pkg.sv
sv/wtcl_front.sv
sv/wtcl_queue.sv
sv/wtcl_back.sv
sv/wheel_torque_command_limiter.sv
tb/wheel_torque_command_limiter_tb.sv
